### design/llxc_pkg.sv
// Shared constants and types for the lead-lag cross-correlation unit.
package llxc_pkg;

    localparam int MAX_SAMPLES_DEF   = 4096;
    localparam int MAX_LAG_STEPS_DEF = 31;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LAG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAG_K      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_FLOOR  = 2'd2;

    localparam logic [31:0] LAG_STEP_RST  = 32'd1000000;
    localparam logic [4:0]  LAG_K_RST     = 5'd10;
    localparam logic [31:0] VAR_FLOOR_RST = 32'd1;

    localparam logic [63:0] SPAN_LIMIT  = 64'd4000000000000000000;
    localparam logic [20:0] Q_POS_LIMIT = 21'd524287;
    localparam logic [20:0] Q_NEG_LIMIT = 21'd524288;
    localparam int          MIN_COUNT   = 3;

    typedef struct packed {
        logic signed [63:0] t_open;
        logic signed [63:0] t_close;
        logic signed [32:0] delta;
    } ivl_t;

    typedef struct packed {
        logic signed [37:0] lag_time;
        logic signed [19:0] corr;
    } curve_t;

endpackage

### design/lead_lag_async_cross_correlation_unit.sv
// Top level of the lead-lag cross-correlation unit.
//
// Samples of two venue mids with a common timestamp load at one transaction per
// clock into two interval memories, one per venue (MAX_SAMPLES entries each,
// one synchronous read port). The sample carrying tlast closes the batch: after
// the variance drain states DRAIN1 and DRAIN2 the batch is checked, and an
// invalid batch yields one result. A valid batch passes through the normalizer
// (partial products, then the square root), then for each of the 2K+1 lags
// through a merge walk over both memories (the B cursor never moving back)
// and a serial divide and rounding. The curve is then streamed out of a small
// result memory, one read state and one output state per point, the peak on
// the last point. No sample is taken from the end of loading until the last
// result has entered the output register.
module lead_lag_async_cross_correlation_unit
    import llxc_pkg::*;
#(
    parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
    parameter int MAX_LAG_STEPS = MAX_LAG_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // venue_a_mid[31:0], venue_b_mid[63:32], stamp[127:64]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // lag_index[5:0], lag_time[43:6], correlation[63:44], peak_lag_time[101:64],
    // peak_correlation[120:102], samples_seen[133:121], zero fill[135:134]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // valid_res[0], overflowed[1]
    output logic [OUT_TUSER_W-1:0] m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W     = $clog2(MAX_SAMPLES);
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int CURVE_D    = 2 * MAX_LAG_STEPS + 1;
    localparam int CADDR_W    = $clog2(CURVE_D);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_COUNT);
    localparam logic [4:0]       K_CAP   = 5'(MAX_LAG_STEPS);

    localparam logic [4:0] S_LOAD      = 5'd0;
    localparam logic [4:0] S_DRAIN1    = 5'd1;
    localparam logic [4:0] S_DRAIN2    = 5'd2;
    localparam logic [4:0] S_CHECK     = 5'd3;
    localparam logic [4:0] S_INVALID   = 5'd4;
    localparam logic [4:0] S_NORM      = 5'd5;
    localparam logic [4:0] S_LAG_START = 5'd6;
    localparam logic [4:0] S_A_RD      = 5'd7;
    localparam logic [4:0] S_B_SKIP    = 5'd8;
    localparam logic [4:0] S_SKIP_CHK  = 5'd9;
    localparam logic [4:0] S_IN_CHK    = 5'd10;
    localparam logic [4:0] S_IN_ISSUE  = 5'd11;
    localparam logic [4:0] S_DIV_INIT  = 5'd12;
    localparam logic [4:0] S_DIV       = 5'd13;
    localparam logic [4:0] S_ROUND     = 5'd14;
    localparam logic [4:0] S_EMIT_RD   = 5'd15;
    localparam logic [4:0] S_EMIT_OUT  = 5'd16;

    // configuration
    logic [31:0] lag_step_reg;
    logic [4:0]  lag_k_reg;
    logic [31:0] var_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_step_reg  <= LAG_STEP_RST;
            lag_k_reg     <= LAG_K_RST;
            var_floor_reg <= VAR_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LAG_STEP:  lag_step_reg  <= cfg_data;
                REG_LAG_K:     lag_k_reg     <= cfg_data[4:0];
                REG_VAR_FLOOR: var_floor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [4:0] k_eff;
    assign k_eff = (lag_k_reg > K_CAP) ? K_CAP : lag_k_reg;

    // batch state
    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    logic [CNT_W-1:0]   sample_cnt_reg;
    logic [CNT_W-1:0]   a_cnt_reg;
    logic [CNT_W-1:0]   b_cnt_reg;
    logic signed [31:0] a_prev_mid_reg;
    logic signed [31:0] b_prev_mid_reg;
    logic signed [63:0] a_prev_ts_reg;
    logic signed [63:0] b_prev_ts_reg;
    logic signed [63:0] first_ts_reg;
    logic signed [63:0] last_ts_reg;
    logic [63:0]        a_var_reg;
    logic [63:0]        b_var_reg;
    logic               sat_reg;

    logic               accept;
    logic               room;
    logic               first;
    logic signed [31:0] in_a;
    logic signed [31:0] in_b;
    logic signed [63:0] in_ts;
    logic signed [32:0] da;
    logic signed [32:0] db;
    logic               a_we;
    logic               b_we;
    logic [32:0]        da_abs;
    logic [32:0]        db_abs;

    assign s_tready = (state_reg == S_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign in_a     = s_tdata[31:0];
    assign in_b     = s_tdata[63:32];
    assign in_ts    = s_tdata[127:64];
    assign room     = sample_cnt_reg < CNT_MAX;
    assign first    = (sample_cnt_reg == '0);
    assign da       = {in_a[31], in_a} - {a_prev_mid_reg[31], a_prev_mid_reg};
    assign db       = {in_b[31], in_b} - {b_prev_mid_reg[31], b_prev_mid_reg};
    assign a_we     = accept && room && !first && (in_a != a_prev_mid_reg) && (a_cnt_reg < CNT_MAX);
    assign b_we     = accept && room && !first && (in_b != b_prev_mid_reg) && (b_cnt_reg < CNT_MAX);
    assign da_abs   = da[32] ? (~da + 33'd1) : da;
    assign db_abs   = db[32] ? (~db + 33'd1) : db;

    // variance pipeline: magnitude, square, accumulate
    logic        va_vld_reg;
    logic        vb_vld_reg;
    logic [31:0] va_mag_reg;
    logic [31:0] vb_mag_reg;
    logic        sqa_vld_reg;
    logic        sqb_vld_reg;
    logic [63:0] sqa_reg;
    logic [63:0] sqb_reg;
    logic [64:0] a_var_sum;
    logic [64:0] b_var_sum;

    assign a_var_sum = {1'b0, a_var_reg} + {1'b0, sqa_reg};
    assign b_var_sum = {1'b0, b_var_reg} + {1'b0, sqb_reg};

    always_ff @(posedge clk)
    begin
        va_mag_reg <= da_abs[31:0];
        vb_mag_reg <= db_abs[31:0];
        sqa_reg    <= va_mag_reg * va_mag_reg;
        sqb_reg    <= vb_mag_reg * vb_mag_reg;
    end

    // interval memories
    ivl_t mem_a [MAX_SAMPLES];
    ivl_t mem_b [MAX_SAMPLES];
    ivl_t a_rd_reg;
    ivl_t b_rd_reg;
    logic a_re;
    logic b_re;
    logic [CNT_W-1:0] a_raddr;
    logic [CNT_W-1:0] b_raddr;

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_cnt_reg[ADDR_W-1:0]] <= '{t_open: a_prev_ts_reg, t_close: in_ts, delta: da};
        end
        if (a_re)
        begin
            a_rd_reg <= mem_a[a_raddr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[b_cnt_reg[ADDR_W-1:0]] <= '{t_open: b_prev_ts_reg, t_close: in_ts, delta: db};
        end
        if (b_re)
        begin
            b_rd_reg <= mem_b[b_raddr[ADDR_W-1:0]];
        end
    end

    // sweep datapath
    logic signed [5:0]  k_reg;
    logic signed [37:0] lag_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   kk_reg;
    logic signed [63:0] total_reg;
    logic               prod_vld_reg;
    logic [63:0]        prod_mag_reg;
    logic               prod_neg_reg;
    logic signed [19:0] best_reg;
    logic signed [37:0] best_lag_reg;
    logic [79:0]        div_num_reg;
    logic [64:0]        div_rem_reg;
    logic [20:0]        div_q_reg;
    logic               div_big_reg;
    logic               div_neg_reg;
    logic [6:0]         div_cnt_reg;
    logic [CADDR_W-1:0] e_reg;

    logic               norm_start;
    logic               norm_done;
    logic [63:0]        norm;

    llxc_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .rv_a  (a_var_reg),
        .rv_b  (b_var_reg),
        .done  (norm_done),
        .norm  (norm)
    );

    logic signed [38:0] lag_prod;
    logic signed [65:0] skip_diff;
    logic signed [65:0] hit_diff;
    logic               skip;
    logic               stop;
    logic [31:0]        pa_mag;
    logic [31:0]        pb_mag;
    logic [32:0]        pa_abs;
    logic [32:0]        pb_abs;

    assign lag_prod  = k_reg * $signed({1'b0, lag_step_reg});
    assign skip_diff = {{2{b_rd_reg.t_close[63]}}, b_rd_reg.t_close}
                     - {{28{lag_reg[37]}}, lag_reg}
                     - {{2{a_rd_reg.t_open[63]}}, a_rd_reg.t_open};
    assign hit_diff  = {{2{b_rd_reg.t_open[63]}}, b_rd_reg.t_open}
                     - {{28{lag_reg[37]}}, lag_reg}
                     - {{2{a_rd_reg.t_close[63]}}, a_rd_reg.t_close};
    assign skip      = skip_diff[65] || (skip_diff == '0);
    assign stop      = !hit_diff[65];
    assign pa_abs    = a_rd_reg.delta[32] ? (~a_rd_reg.delta + 33'd1) : a_rd_reg.delta;
    assign pb_abs    = b_rd_reg.delta[32] ? (~b_rd_reg.delta + 33'd1) : b_rd_reg.delta;
    assign pa_mag    = pa_abs[31:0];
    assign pb_mag    = pb_abs[31:0];

    always_ff @(posedge clk)
    begin
        prod_mag_reg <= pa_mag * pb_mag;
        prod_neg_reg <= a_rd_reg.delta[32] ^ b_rd_reg.delta[32];
    end

    // product saturation and running sum
    logic signed [63:0] pv;
    logic               p_sat;
    logic signed [64:0] tsum;
    logic signed [63:0] total_next;
    logic               t_sat;

    always_comb
    begin
        p_sat = 1'b0;
        if (!prod_neg_reg)
        begin
            if (prod_mag_reg[63])
            begin
                pv    = {1'b0, {63{1'b1}}};
                p_sat = 1'b1;
            end
            else
            begin
                pv = prod_mag_reg;
            end
        end
        else if (prod_mag_reg[63])
        begin
            pv    = {1'b1, 63'd0};
            p_sat = (prod_mag_reg[62:0] != '0);
        end
        else
        begin
            pv = -$signed(prod_mag_reg);
        end
        tsum  = {total_reg[63], total_reg} + {pv[63], pv};
        t_sat = (tsum[64] != tsum[63]);
        if (t_sat)
        begin
            total_next = tsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            total_next = tsum[63:0];
        end
    end

    // divide and round
    logic [63:0] cov_mag;
    logic [64:0] rem_sh;
    logic        qbit;
    logic [20:0] lim;
    logic        rnd_up;
    logic [20:0] q_r;
    logic [20:0] q_fin;
    logic signed [19:0] corr_new;

    assign cov_mag = total_reg[63] ? (~total_reg + 64'd1) : total_reg;
    assign rem_sh  = {div_rem_reg[63:0], div_num_reg[79]};
    assign qbit    = rem_sh >= {1'b0, norm};
    assign lim     = div_neg_reg ? Q_NEG_LIMIT : Q_POS_LIMIT;
    assign rnd_up  = {div_rem_reg[63:0], 1'b0} >= {1'b0, norm};
    assign q_r     = div_q_reg + {20'd0, rnd_up};

    always_comb
    begin
        if (div_big_reg || div_q_reg > lim || q_r > lim)
        begin
            q_fin = lim;
        end
        else
        begin
            q_fin = q_r;
        end
        if (norm == '0)
        begin
            corr_new = '0;
        end
        else if (div_neg_reg)
        begin
            corr_new = -$signed(q_fin[19:0]);
        end
        else
        begin
            corr_new = q_fin[19:0];
        end
    end

    // curve memory
    curve_t             curve_mem [CURVE_D];
    curve_t             c_rd_reg;
    logic signed [6:0]  cidx;
    logic [6:0]         e_wide;
    logic               e_last;
    logic               k_last;
    logic               c_we;
    logic               c_re;

    assign cidx   = {k_reg[5], k_reg} + $signed({2'b00, k_eff});
    assign e_wide = 7'(e_reg);
    assign e_last = (e_wide == {1'b0, k_eff, 1'b0});
    assign k_last = (k_reg == $signed({1'b0, k_eff}));
    assign c_we   = (state_reg == S_ROUND);
    assign c_re   = (state_reg == S_EMIT_RD);

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            curve_mem[cidx[CADDR_W-1:0]] <= '{lag_time: lag_reg, corr: corr_new};
        end
        if (c_re)
        begin
            c_rd_reg <= curve_mem[e_reg];
        end
    end

    // validity
    logic signed [64:0] span;
    logic               batch_ok;

    assign span     = {last_ts_reg[63], last_ts_reg} - {first_ts_reg[63], first_ts_reg};
    assign batch_ok = (sample_cnt_reg >= CNT_MIN) && (lag_step_reg != '0) && (k_eff != '0)
                   && !span[64] && (span != '0) && (span[63:0] <= SPAN_LIMIT)
                   && (a_cnt_reg >= CNT_MIN) && (b_cnt_reg >= CNT_MIN)
                   && (a_var_reg >= {32'd0, var_floor_reg})
                   && (b_var_reg >= {32'd0, var_floor_reg});

    // output register
    logic               out_vld_reg;
    logic               out_free;
    logic               out_load;
    logic               out_ok_reg;
    logic [5:0]         out_lag_idx_reg;
    logic [37:0]        out_lag_time_reg;
    logic [19:0]        out_corr_reg;
    logic [37:0]        out_peak_lag_reg;
    logic [18:0]        out_peak_reg;
    logic [12:0]        out_seen_reg;
    logic               out_sat_reg;
    logic               out_last_reg;
    logic [31:0]        seen_wide;
    logic               batch_clear;

    assign out_free    = !out_vld_reg || m_tready;
    assign out_load    = out_free && (state_reg == S_INVALID || state_reg == S_EMIT_OUT);
    assign batch_clear = out_load && (state_reg == S_INVALID || e_last);
    assign seen_wide   = 32'(sample_cnt_reg);
    assign norm_start  = (state_reg == S_CHECK) && batch_ok;

    always_comb
    begin
        a_re    = 1'b0;
        b_re    = 1'b0;
        a_raddr = i_reg;
        b_raddr = j_reg;
        unique case (state_reg)
            S_A_RD:     a_re = (i_reg < a_cnt_reg);
            S_B_SKIP:   b_re = (j_reg < b_cnt_reg);
            S_IN_ISSUE:
            begin
                b_re    = (kk_reg < b_cnt_reg);
                b_raddr = kk_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:      if (accept && s_tlast) state_next = S_DRAIN1;
            S_DRAIN1:    state_next = S_DRAIN2;
            S_DRAIN2:    state_next = S_CHECK;
            S_CHECK:     state_next = batch_ok ? S_NORM : S_INVALID;
            S_INVALID:   if (out_free) state_next = S_LOAD;
            S_NORM:      if (norm_done) state_next = S_LAG_START;
            S_LAG_START: state_next = S_A_RD;
            S_A_RD:      state_next = (i_reg < a_cnt_reg) ? S_B_SKIP : S_DIV_INIT;
            S_B_SKIP:    state_next = (j_reg < b_cnt_reg) ? S_SKIP_CHK : S_A_RD;
            S_SKIP_CHK:  state_next = skip ? S_B_SKIP : S_IN_CHK;
            S_IN_CHK:    state_next = stop ? S_A_RD : S_IN_ISSUE;
            S_IN_ISSUE:  state_next = (kk_reg < b_cnt_reg) ? S_IN_CHK : S_A_RD;
            S_DIV_INIT:  state_next = (norm == '0) ? S_ROUND : S_DIV;
            S_DIV:       if (div_cnt_reg == 7'd79) state_next = S_ROUND;
            S_ROUND:     state_next = k_last ? S_EMIT_RD : S_LAG_START;
            S_EMIT_RD:   state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = e_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default:     state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            sample_cnt_reg <= '0;
            a_cnt_reg      <= '0;
            b_cnt_reg      <= '0;
            a_prev_mid_reg <= '0;
            b_prev_mid_reg <= '0;
            a_prev_ts_reg  <= '0;
            b_prev_ts_reg  <= '0;
            first_ts_reg   <= '0;
            last_ts_reg    <= '0;
            a_var_reg      <= '0;
            b_var_reg      <= '0;
            sat_reg        <= 1'b0;
            va_vld_reg     <= 1'b0;
            vb_vld_reg     <= 1'b0;
            sqa_vld_reg    <= 1'b0;
            sqb_vld_reg    <= 1'b0;
            prod_vld_reg   <= 1'b0;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            kk_reg         <= '0;
            e_reg          <= '0;
            div_cnt_reg    <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            va_vld_reg   <= a_we;
            vb_vld_reg   <= b_we;
            sqa_vld_reg  <= va_vld_reg;
            sqb_vld_reg  <= vb_vld_reg;
            prod_vld_reg <= (state_reg == S_IN_CHK) && !stop;

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (batch_clear)
            begin
                sample_cnt_reg <= '0;
                a_cnt_reg      <= '0;
                b_cnt_reg      <= '0;
                a_prev_mid_reg <= '0;
                b_prev_mid_reg <= '0;
                a_prev_ts_reg  <= '0;
                b_prev_ts_reg  <= '0;
                first_ts_reg   <= '0;
                a_var_reg      <= '0;
                b_var_reg      <= '0;
                sat_reg        <= 1'b0;
            end
            else
            begin
                if (accept)
                begin
                    last_ts_reg <= in_ts;
                    if (!room)
                    begin
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        sample_cnt_reg <= sample_cnt_reg + 1'b1;
                        if (first)
                        begin
                            first_ts_reg   <= in_ts;
                            a_prev_mid_reg <= in_a;
                            b_prev_mid_reg <= in_b;
                            a_prev_ts_reg  <= in_ts;
                            b_prev_ts_reg  <= in_ts;
                        end
                    end
                end
                if (a_we)
                begin
                    a_cnt_reg      <= a_cnt_reg + 1'b1;
                    a_prev_mid_reg <= in_a;
                    a_prev_ts_reg  <= in_ts;
                end
                if (b_we)
                begin
                    b_cnt_reg      <= b_cnt_reg + 1'b1;
                    b_prev_mid_reg <= in_b;
                    b_prev_ts_reg  <= in_ts;
                end
                if (sqa_vld_reg)
                begin
                    if (a_var_sum[64])
                    begin
                        a_var_reg <= '1;
                        sat_reg   <= 1'b1;
                    end
                    else
                    begin
                        a_var_reg <= a_var_sum[63:0];
                    end
                end
                if (sqb_vld_reg)
                begin
                    if (b_var_sum[64])
                    begin
                        b_var_reg <= '1;
                        sat_reg   <= 1'b1;
                    end
                    else
                    begin
                        b_var_reg <= b_var_sum[63:0];
                    end
                end
                if (prod_vld_reg && (p_sat || t_sat))
                begin
                    sat_reg <= 1'b1;
                end
            end

            unique case (state_reg)
                S_CHECK:     k_reg <= -$signed({1'b0, k_eff});
                S_LAG_START:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                S_B_SKIP:    if (j_reg >= b_cnt_reg) i_reg <= i_reg + 1'b1;
                S_SKIP_CHK:
                begin
                    if (skip)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        kk_reg <= j_reg;
                    end
                end
                S_IN_CHK:
                begin
                    if (stop)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        kk_reg <= kk_reg + 1'b1;
                    end
                end
                S_IN_ISSUE:  if (kk_reg >= b_cnt_reg) i_reg <= i_reg + 1'b1;
                S_DIV_INIT:  div_cnt_reg <= '0;
                S_DIV:       div_cnt_reg <= div_cnt_reg + 7'd1;
                S_ROUND:
                begin
                    k_reg <= k_reg + 6'sd1;
                    e_reg <= '0;
                end
                S_EMIT_OUT:  if (out_free) e_reg <= e_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_CHECK:
            begin
                best_reg     <= '0;
                best_lag_reg <= '0;
            end
            S_LAG_START:
            begin
                lag_reg   <= lag_prod[37:0];
                total_reg <= '0;
            end
            S_DIV_INIT:
            begin
                div_num_reg <= {cov_mag, 16'd0};
                div_rem_reg <= '0;
                div_q_reg   <= '0;
                div_big_reg <= 1'b0;
                div_neg_reg <= total_reg[63];
            end
            S_DIV:
            begin
                div_num_reg <= {div_num_reg[78:0], 1'b0};
                div_rem_reg <= qbit ? (rem_sh - {1'b0, norm}) : rem_sh;
                div_q_reg   <= {div_q_reg[19:0], qbit};
                div_big_reg <= div_big_reg | div_q_reg[20];
            end
            S_ROUND:
            begin
                if (corr_new > best_reg)
                begin
                    best_reg     <= corr_new;
                    best_lag_reg <= lag_reg;
                end
            end
            default: ;
        endcase
        if (prod_vld_reg)
        begin
            total_reg <= total_next;
        end
        if (out_load)
        begin
            out_seen_reg <= seen_wide[12:0];
            out_sat_reg  <= sat_reg;
            out_last_reg <= (state_reg == S_INVALID) || e_last;
            if (state_reg == S_INVALID)
            begin
                out_ok_reg       <= 1'b0;
                out_lag_idx_reg  <= '0;
                out_lag_time_reg <= '0;
                out_corr_reg     <= '0;
                out_peak_lag_reg <= '0;
                out_peak_reg     <= '0;
            end
            else
            begin
                out_ok_reg       <= 1'b1;
                out_lag_idx_reg  <= 6'(e_wide - {2'b00, k_eff});
                out_lag_time_reg <= c_rd_reg.lag_time;
                out_corr_reg     <= c_rd_reg.corr;
                out_peak_lag_reg <= e_last ? best_lag_reg : '0;
                out_peak_reg     <= e_last ? best_reg[18:0] : '0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_sat_reg, out_ok_reg};
    assign m_tdata  = {2'b00, out_seen_reg, out_peak_reg, out_peak_lag_reg,
                       out_corr_reg, out_lag_time_reg, out_lag_idx_reg};

endmodule

### design/llxc_norm.sv
// Normalizer: floor(sqrt(rv_a * rv_b)) by partial products and a bit-pair square root.
module llxc_norm
    import llxc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rv_a,
    input  logic [63:0] rv_b,
    output logic        done,
    output logic [63:0] norm
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_ROOT = 2'd2;

    logic [1:0]   phase_reg;
    logic [5:0]   cnt_reg;
    logic         done_reg;
    logic [127:0] acc_reg;
    logic [127:0] op_reg;
    logic [64:0]  rem_reg;
    logic [63:0]  root_reg;

    logic [31:0]  half_a;
    logic [31:0]  half_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] acc_next;
    logic [66:0]  rem_sh;
    logic [66:0]  trial;
    logic [66:0]  rem_sub;
    logic         fits;

    always_comb
    begin
        half_a = cnt_reg[1] ? rv_a[63:32] : rv_a[31:0];
        half_b = cnt_reg[0] ? rv_b[63:32] : rv_b[31:0];
        pp     = half_a * half_b;
        case (cnt_reg[1:0]) inside
            2'd0:       pp_sh = {64'd0, pp};
            2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
            default:    pp_sh = {pp, 64'd0};
        endcase
        acc_next = acc_reg + pp_sh;
        rem_sh   = {rem_reg, op_reg[127:126]};
        trial    = {1'b0, root_reg, 2'b01};
        fits     = rem_sh >= trial;
        rem_sub  = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_MUL;
                        cnt_reg   <= '0;
                    end
                end
                PH_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        phase_reg <= PH_ROOT;
                        cnt_reg   <= '0;
                    end
                end
                PH_ROOT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            acc_reg <= '0;
        end
        else if (phase_reg == PH_MUL)
        begin
            acc_reg <= acc_next;
            if (cnt_reg[1:0] == 2'd3)
            begin
                op_reg   <= acc_next;
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        else if (phase_reg == PH_ROOT)
        begin
            op_reg <= {op_reg[125:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sub[64:0];
                root_reg <= {root_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[64:0];
                root_reg <= {root_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign norm = root_reg;

endmodule

### design/llxc_checker.sv
// Port-level checks for the lead-lag cross-correlation unit, bound to the top level.
module llxc_checker
    import llxc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser,
    input logic                   m_tlast
);

    a_close_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after the closing transaction");

    a_invalid_is_lone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[120:0] == '0))
        else $error("invalid result not a lone zeroed last transaction");

    a_peak_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[120:64] == '0))
        else $error("peak fields set before the last curve point");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind lead_lag_async_cross_correlation_unit llxc_checker u_llxc_checker (.*);
